### src/pctd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

	// table geometry and code limits
	localparam int TABLE_DEPTH   = 256;
	localparam int IDX_W         = 8;
	localparam int USED_W        = 9;
	localparam int MAX_CODE_BITS = 32;
	localparam int LEN_W         = 6;
	localparam int SYM_W         = 32;
	localparam int SLEN_W        = 3;
	localparam int BYTE_W        = 8;
	localparam int BIT_CNT_W     = 3;

	// index of the first bit taken from a data byte
	localparam int FIRST_BIT = 7;

	// input word kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// symbol length limits
	localparam logic [SLEN_W-1:0] SLEN_MIN = SLEN_W'(1);
	localparam logic [SLEN_W-1:0] SLEN_MAX = SLEN_W'(4);

	typedef struct packed {
		logic                kind;
		logic [IDX_W-1:0]    entry_index;
		logic [LEN_W-1:0]    code_length;
		logic [MAX_CODE_BITS-1:0] code_value;
		logic [SYM_W-1:0]    symbol_value;
		logic [SLEN_W-1:0]   symbol_length;
		logic [BYTE_W-1:0]   data_byte;
	} in_word_t;

	typedef struct packed {
		logic [SYM_W-1:0]  out_symbol;
		logic [SLEN_W-1:0] out_length;
		logic              overflow_error;
		logic              last;
	} out_word_t;

	typedef struct packed {
		logic [MAX_CODE_BITS-1:0] code_bits;
		logic [LEN_W-1:0]         code_width;
		logic [SYM_W-1:0]         symbol;
		logic [SLEN_W-1:0]        symbol_len;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

`default_nettype wire

### src/prefix_code_table_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Prefix code decoder with a loadable code table. A word is taken when start
// is high and busy is low. A load word writes one table slot and gives no
// result. A data word is decoded one bit at a time, bit 7 first: the bit is
// shifted into the code accumulator, then the table is walked through its
// single read port one slot per cycle from slot 0 up, stopping at the first
// slot whose length and bits equal the accumulator. Each bit passes through a
// step state and then a scan state; the scan reads slots 0 to N-1 at most, N
// being entries_in_use capped at 256, and reads none when no slot is in use.
// After the eighth bit a flush state keeps busy high and marks the final
// result with last. Results appear on result for exactly one cycle with
// result_valid high; the receiver cannot stall them, they may come on back to
// back cycles, and the final one of a word shows up in the first cycle in
// which busy is low. An accumulator that reaches 32 bits with no match gives
// an error result (overflow_error high, out_length zero) and clears.
// entries_in_use is written through cfg_we / cfg_data while the block is idle;
// the user must keep to this, the block does not enforce it; there is no reset pass.

module prefix_code_table_decoder (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire pctd_pkg::in_word_t     in_word,
	input  wire                         cfg_we,
	input  wire [pctd_pkg::USED_W-1:0]  cfg_data,
	output logic                        result_valid,
	output pctd_pkg::out_word_t         result
);

	import pctd_pkg::*;

	// control state
	state_t                    state_q, state_d;
	logic [USED_W-1:0]         entries_q;
	logic [USED_W-1:0]         used_lim;
	logic [USED_W-1:0]         idx_q;
	logic [BIT_CNT_W-1:0]      bits_left_q;
	logic                      rd_vld_s1;
	logic                      hold_vld_q;
	logic                      res_vld_q;

	// code accumulator, cleared on every match or overflow
	logic [MAX_CODE_BITS-1:0]  acc_q;
	logic [LEN_W-1:0]          cnt_q;

	// payload
	logic [BYTE_W-1:0]         byte_q;
	out_word_t                 hold_q;
	out_word_t                 res_q;
	out_word_t                 new_res;

	// code table
	entry_t                    mem_q [TABLE_DEPTH];
	entry_t                    rd_s1;
	entry_t                    wr_entry;
	logic                      wr_en;
	logic [SYM_W-1:0]          sym_mask;
	logic [SLEN_W-1:0]         slen_clamp;

	// scan control
	logic                      scan_issue;
	logic                      hit;
	logic                      scan_end;
	logic                      ovf;
	logic [MAX_CODE_BITS-1:0]  code_mask;
	logic                      accept_data;

	// slots beyond the table size never take part
	assign used_lim = (entries_q > USED_W'(TABLE_DEPTH)) ? USED_W'(TABLE_DEPTH) : entries_q;

	assign busy        = (state_q != ST_IDLE);
	assign accept_data = start && (state_q == ST_IDLE) && (in_word.kind == KIND_DATA);
	assign wr_en       = start && (state_q == ST_IDLE) && (in_word.kind == KIND_LOAD);

	// load path: clamp the symbol length and zero bytes past it
	always_comb begin
		slen_clamp = in_word.symbol_length;
		if (in_word.symbol_length < SLEN_MIN) begin
			slen_clamp = SLEN_MIN;
		end else if (in_word.symbol_length > SLEN_MAX) begin
			slen_clamp = SLEN_MAX;
		end
		case (slen_clamp)
			SLEN_W'(1): sym_mask = SYM_W'(32'h0000_00FF);
			SLEN_W'(2): sym_mask = SYM_W'(32'h0000_FFFF);
			SLEN_W'(3): sym_mask = SYM_W'(32'h00FF_FFFF);
			default:    sym_mask = {SYM_W{1'b1}};
		endcase
		wr_entry.code_bits  = in_word.code_value;
		wr_entry.code_width = in_word.code_length;
		wr_entry.symbol     = in_word.symbol_value & sym_mask;
		wr_entry.symbol_len = slen_clamp;
	end

	// table memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[in_word.entry_index] <= wr_entry;
		end
		rd_s1 <= mem_q[idx_q[IDX_W-1:0]];
	end

	// compare of the slot read last cycle against the accumulator
	assign code_mask = ~({MAX_CODE_BITS{1'b1}} << rd_s1.code_width);

	always_comb begin
		scan_issue = (state_q == ST_SCAN) && (idx_q < used_lim);
		hit        = (state_q == ST_SCAN) && rd_vld_s1
		             && (rd_s1.code_width == cnt_q)
		             && ((rd_s1.code_bits & code_mask) == acc_q);
		// scan is over on a hit, or once every slot in use was read and checked
		scan_end   = (state_q == ST_SCAN)
		             && (hit || (!rd_vld_s1 && (idx_q >= used_lim)));
		ovf        = scan_end && !hit && (cnt_q == LEN_W'(MAX_CODE_BITS));

		new_res.out_symbol     = hit ? rd_s1.symbol : '0;
		new_res.out_length     = hit ? rd_s1.symbol_len : '0;
		new_res.overflow_error = ovf;
		new_res.last           = 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_data) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = (bits_left_q == '0) ? ST_FLUSH : ST_STEP;
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			entries_q   <= '0;
			idx_q       <= '0;
			bits_left_q <= '0;
			rd_vld_s1   <= 1'b0;
			hold_vld_q  <= 1'b0;
			res_vld_q   <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue && !hit;
			// the held result leaves when a fresh one replaces it or at the end of the byte
			res_vld_q <= hold_vld_q && ((scan_end && (hit || ovf)) || (state_q == ST_FLUSH));

			if (cfg_we) begin
				entries_q <= cfg_data;
			end

			if (accept_data) begin
				bits_left_q <= BIT_CNT_W'(FIRST_BIT);
			end

			// shift the next code bit in and restart the table walk
			if (state_q == ST_STEP) begin
				acc_q <= {acc_q[MAX_CODE_BITS-2:0], byte_q[BYTE_W-1]};
				cnt_q <= cnt_q + LEN_W'(1);
				idx_q <= '0;
			end else if (scan_issue) begin
				idx_q <= idx_q + USED_W'(1);
			end

			if (scan_end) begin
				if (bits_left_q != '0) begin
					bits_left_q <= bits_left_q - BIT_CNT_W'(1);
				end
				// a fresh result pushes the held one out, now known not last
				if (hit || ovf) begin
					acc_q      <= '0;
					cnt_q      <= '0;
					hold_vld_q <= 1'b1;
				end
			end

			// end of the byte: the held result is the last one
			if (state_q == ST_FLUSH) begin
				hold_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept_data) begin
			byte_q <= in_word.data_byte;
		end else if (state_q == ST_STEP) begin
			byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
		end

		if (scan_end && (hit || ovf)) begin
			hold_q <= new_res;
			res_q  <= hold_q;
		end

		if (state_q == ST_FLUSH) begin
			res_q <= '{out_symbol:     hold_q.out_symbol,
			           out_length:     hold_q.out_length,
			           overflow_error: hold_q.overflow_error,
			           last:           1'b1};
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// an error result carries no symbol bytes, a match carries at least one
	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.overflow_error == (result.out_length == '0)))
		else $error("result length disagrees with error flag");

	// accumulator never holds more than the longest code
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LEN_W'(MAX_CODE_BITS))
		else $error("code accumulator overran");

	// the flush cycle empties the holding register and frees the block
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (!hold_vld_q && !busy))
		else $error("flush left a held result or stayed busy");

	// results only come out of a data word being worked on
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result while idle");

endmodule

`default_nettype wire

### dv/prefix_code_table_decoder_tb.sv
`timescale 1ns / 1ps

module prefix_code_table_decoder_tb;

	import pctd_pkg::*;

	// generous guard; a correct run stays far below this
	localparam int CYCLE_LIMIT = 2_000_000;

	// mirror of the decoder: code table, bit accumulator and the symbols it must emit
	class decode_scoreboard;
		entry_t    slots[TABLE_DEPTH];
		int        used_slots;
		logic [MAX_CODE_BITS-1:0] acc_bits;
		int        acc_count;
		out_word_t expected_symbols[$];
		int        loads_seen;
		int        bytes_seen;
		int        results_checked;
		int        overflows_checked;
		int        errors;

		function new();
			used_slots = 0;
			acc_bits = '0;
			acc_count = 0;
			loads_seen = 0;
			bytes_seen = 0;
			results_checked = 0;
			overflows_checked = 0;
			errors = 0;
		endfunction

		function int waiting();
			return expected_symbols.size();
		endfunction

		// entries_in_use saturates at the table depth
		function void set_entries(logic [USED_W-1:0] v);
			used_slots = (v > TABLE_DEPTH) ? TABLE_DEPTH : int'(v);
		endfunction

		// note an accepted input word and queue the symbols it decodes to
		function void note_word(in_word_t w);
			logic [63:0]       m;
			logic [SLEN_W-1:0] sl;
			logic [SYM_W-1:0]  sym;
			out_word_t         r;
			int                n_out;
			bit                hit;
			if (w.kind == KIND_LOAD) begin
				// symbol length is clamped to one..four bytes when stored
				sl = w.symbol_length;
				if (sl < SLEN_MIN) sl = SLEN_MIN;
				if (sl > SLEN_MAX) sl = SLEN_MAX;
				slots[w.entry_index].code_bits = w.code_value;
				slots[w.entry_index].code_width = w.code_length;
				slots[w.entry_index].symbol = w.symbol_value;
				slots[w.entry_index].symbol_len = sl;
				loads_seen++;
				return;
			end
			bytes_seen++;
			n_out = 0;
			for (int b = FIRST_BIT; b >= 0; b--) begin
				acc_bits = {acc_bits[MAX_CODE_BITS-2:0], w.data_byte[b]};
				acc_count++;
				hit = 1'b0;
				// lowest matching slot wins; lengths of zero or above the max never match
				for (int i = 0; i < used_slots && !hit; i++) begin
					if (slots[i].code_width != 0 && slots[i].code_width <= MAX_CODE_BITS &&
							slots[i].code_width == acc_count) begin
						m = (64'd1 << slots[i].code_width) - 64'd1;
						if ((slots[i].code_bits & m[MAX_CODE_BITS-1:0]) == acc_bits) begin
							sym = slots[i].symbol;
							if (slots[i].symbol_len < SLEN_MAX) begin
								m = (64'd1 << (slots[i].symbol_len * 8)) - 64'd1;
								sym = sym & m[SYM_W-1:0];
							end
							r.out_symbol = sym;
							r.out_length = slots[i].symbol_len;
							r.overflow_error = 1'b0;
							r.last = 1'b0;
							expected_symbols.insert(expected_symbols.size(), r);
							n_out++;
							hit = 1'b1;
						end
					end
				end
				if (hit || acc_count >= MAX_CODE_BITS) begin
					if (!hit) begin
						r = '0;
						r.overflow_error = 1'b1;
						expected_symbols.insert(expected_symbols.size(), r);
						n_out++;
					end
					acc_bits = '0;
					acc_count = 0;
				end
			end
			if (n_out > 0) begin
				r = expected_symbols[expected_symbols.size() - 1];
				r.last = 1'b1;
				expected_symbols[expected_symbols.size() - 1] = r;
			end
		endfunction

		// compare a result word with the oldest queued symbol
		function void check_result(out_word_t r);
			out_word_t e;
			if (expected_symbols.size() == 0) begin
				$error("result with nothing pending: out_symbol %h out_length %0d err %0d last %0d",
					r.out_symbol, r.out_length, r.overflow_error, r.last);
				errors++;
				return;
			end
			e = expected_symbols.pop_front();
			results_checked++;
			if (e.overflow_error) overflows_checked++;
			if (r.out_symbol !== e.out_symbol) begin
				$error("out_symbol: expected %h, actual %h", e.out_symbol, r.out_symbol);
				errors++;
			end
			if (r.out_length !== e.out_length) begin
				$error("out_length: expected %0d, actual %0d", e.out_length, r.out_length);
				errors++;
			end
			if (r.overflow_error !== e.overflow_error) begin
				$error("overflow_error: expected %0d, actual %0d",
					e.overflow_error, r.overflow_error);
				errors++;
			end
			if (r.last !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, r.last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_word_t          in_word;
	logic              cfg_we;
	logic [USED_W-1:0] cfg_data;
	logic              result_valid;
	out_word_t         result;

	decode_scoreboard sb = new();

	// slots that hold a loaded entry; only these may be put in use
	bit slot_written[TABLE_DEPTH];
	// bits of well-formed code words not yet packed into data bytes
	bit code_stream[$];
	// chance in a hundred that the sender idles before a word
	int idle_pct = 19;

	prefix_code_table_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.in_word      (in_word),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// results cannot be held off: take every strobed word at the edge ending its cycle
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1)
			sb.check_result(result);
	end

	// hang guard
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// every field random; callers then fix the kind and the fields that matter
	function in_word_t rand_word();
		in_word_t w;
		w.kind = 1'($urandom_range(1));
		w.entry_index = IDX_W'($urandom);
		w.code_length = LEN_W'($urandom);
		w.code_value = $urandom;
		w.symbol_value = $urandom;
		w.symbol_length = SLEN_W'($urandom);
		w.data_byte = BYTE_W'($urandom);
		return w;
	endfunction

	// present one word, hold it until busy is low at an edge, then note it
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		sb.note_word(w);
	endtask

	task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] len,
			input logic [MAX_CODE_BITS-1:0] code, input logic [SYM_W-1:0] sym,
			input logic [SLEN_W-1:0] slen);
		in_word_t w;
		w = rand_word();
		w.kind = KIND_LOAD;
		w.entry_index = idx;
		w.code_length = len;
		w.code_value = code;
		w.symbol_value = sym;
		w.symbol_length = slen;
		slot_written[idx] = 1'b1;
		send_word(w);
	endtask

	// mostly codes of the phase length, some of any valid length, a few of any 6-bit length
	task automatic load_random(input int idx, input int base_len);
		int r;
		logic [LEN_W-1:0]  len;
		logic [SLEN_W-1:0] slen;
		r = $urandom_range(99);
		if (r < 75)
			len = LEN_W'(base_len);
		else if (r < 90)
			len = LEN_W'($urandom_range(1, MAX_CODE_BITS));
		else
			len = LEN_W'($urandom_range(63));
		if ($urandom_range(99) < 85)
			slen = SLEN_W'($urandom_range(1, 4));
		else
			slen = SLEN_W'($urandom_range(7));
		load_entry(IDX_W'(idx), len, $urandom, $urandom, slen);
	endtask

	task automatic send_data(input logic [BYTE_W-1:0] b);
		in_word_t w;
		w = rand_word();
		w.kind = KIND_DATA;
		w.data_byte = b;
		send_word(w);
	endtask

	// next byte of a stream made of code words taken from slots in use
	function logic [BYTE_W-1:0] next_stream_byte();
		logic [BYTE_W-1:0] v;
		int i;
		int tries;
		int len;
		while (code_stream.size() < BYTE_W) begin
			tries = 0;
			len = 0;
			while (len == 0 && tries < 8 && sb.used_slots > 0) begin
				i = $urandom_range(sb.used_slots - 1);
				if (sb.slots[i].code_width >= 1 && sb.slots[i].code_width <= MAX_CODE_BITS)
					len = sb.slots[i].code_width;
				tries++;
			end
			if (len == 0) begin
				for (int k = 0; k < BYTE_W; k++)
					code_stream.insert(code_stream.size(), 1'($urandom_range(1)));
			end else begin
				for (int k = len - 1; k >= 0; k--)
					code_stream.insert(code_stream.size(), sb.slots[i].code_bits[k]);
			end
		end
		for (int k = BYTE_W - 1; k >= 0; k--) v[k] = code_stream.pop_front();
		return v;
	endfunction

	// drain: every queued symbol in, then the worst word time for the current setting
	task automatic settle();
		start <= 1'b0;
		while (sb.waiting() != 0) @(posedge clk);
		repeat (8 * (sb.used_slots + 3) + 4) @(posedge clk);
	endtask

	task automatic set_entries(input logic [USED_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		sb.set_entries(v);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_words();
		// empty table in use: 32 unmatched bits give one overflow on the fourth byte
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'hA5);
		send_data(8'h5A);
		// zero code length, symbol length zero stored as one
		load_entry(8'd0, 6'd0, 32'hFFFF_FFFF, 32'h1111_1111, 3'd0);
		// code longer than the max never matches, symbol length seven stored as four
		load_entry(8'd1, 6'd33, 32'h0000_0001, 32'h2222_2222, 3'd7);
		// bits above the code length are ignored
		load_entry(8'd2, 6'd2, 32'hFFFF_FFFE, 32'hDEAD_BEEF, 3'd1);
		// same code as slot 2, so slot 2 wins
		load_entry(8'd3, 6'd2, 32'h0000_0002, 32'hCAFE_F00D, 3'd4);
		load_entry(8'd4, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4);
		load_entry(8'd5, 6'd3, 32'h0000_0003, 32'h0000_BEEF, 3'd2);
		load_entry(8'd6, 6'd63, 32'h0000_0000, 32'h4444_4444, 3'd5);
		load_entry(8'd7, 6'd8, 32'h0000_0000, 32'h0012_3456, 3'd3);
		settle();
		set_entries(USED_W'(8));
		send_data(8'h80);
		send_data(8'h00);
		send_data(8'h6D);
		// one-bit code: once aligned, every set bit is a symbol, eight per byte
		load_entry(8'd8, 6'd1, 32'hFFFF_FFFF, 32'h0000_0041, 3'd1);
		settle();
		set_entries(USED_W'(9));
		repeat (5) send_data(8'hFF);
		send_data(8'h55);
	endtask

	initial begin
		logic [USED_W-1:0] plan[11];
		int n_eff;
		int base_len;
		int nwords;
		int r;
		plan = '{9'd0, 9'd3, 9'd1, 9'd12, 9'd7, 9'd30, 9'd2, 9'd64, 9'd511, 9'd256, 9'd5};
		arst_n <= 1'b0;
		start <= 1'b0;
		in_word <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_words();

		for (int p = 0; p < 11; p++) begin
			n_eff = (plan[p] > TABLE_DEPTH) ? TABLE_DEPTH : int'(plan[p]);
			base_len = $urandom_range(2, 8);
			// fill every slot this setting puts in use before it takes effect
			for (int s = 0; s < n_eff; s++)
				if (!slot_written[s]) load_random(s, base_len);
			settle();
			set_entries(plan[p]);
			// one phase runs with the sender never idling
			idle_pct = (p == 3) ? 0 : 19;
			nwords = (n_eff >= 64) ? 10 : 14;
			for (int k = 0; k < nwords; k++) begin
				r = $urandom_range(99);
				if (r < 10)
					load_random((n_eff > 0) ? $urandom_range(n_eff - 1) : $urandom_range(255),
						base_len);
				else if (r < 28)
					send_data(BYTE_W'($urandom_range(255)));
				else
					send_data(next_stream_byte());
			end
		end

		settle();
		$display("covered %0d table loads and %0d data bytes over eleven table sizes up to full",
			sb.loads_seen, sb.bytes_seen);
		$display("checked %0d result words, %0d of them overflow errors",
			sb.results_checked, sb.overflows_checked);
		if (sb.errors == 0 && sb.waiting() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
